// File: rtl/snapped_window_tracker_hysteresis_core_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef SNAPPED_WINDOW_TRACKER_HYSTERESIS_CORE_MACROS_SVH
`define SNAPPED_WINDOW_TRACKER_HYSTERESIS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWTH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWTH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/swth_pkg.sv
// Types, constants and helper functions for the snapped window tracker.
package swth_pkg;

    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    localparam int TILE_W     = SIZE_W - 3;
    localparam int CALC_W     = COORD_W + 2;
    localparam int DIV_STEPS  = CALC_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;
    localparam int IN_DATA_W  = 2 * COORD_W;
    localparam int OUT_FLD_W  = 2 * COORD_W + 2 * SIZE_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;
    localparam int OUT_USER_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd4;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 15'd256;

    typedef logic signed [CALC_W-1:0] calc_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SIZE, ST_BOUND, ST_BASE, ST_LAUNCH,
        ST_WAIT, ST_CENTER, ST_FAR, ST_DECIDE, ST_OUT
    } trk_state_t;

    // Which corner the shared snap unit is working on
    typedef enum logic [1:0] {
        SEL_CENTER_X, SEL_CENTER_Y, SEL_VIEWER_X, SEL_VIEWER_Y
    } snap_sel_t;

    typedef enum logic [1:0] {SN_IDLE, SN_DIV, SN_FIX} snap_state_t;

    typedef struct packed {
        logic              start;
        calc_t             a;
        logic [TILE_W-1:0] tile;
        calc_t             lo;
        calc_t             hi;
    } snap_req_t;

    typedef struct packed {
        logic  done;
        calc_t corner;
    } snap_rsp_t;

    function automatic calc_t sext_coord(input logic [COORD_W-1:0] v);
        return calc_t'({{(CALC_W-COORD_W){v[COORD_W-1]}}, v});
    endfunction

    function automatic calc_t zext_size(input logic [SIZE_W-1:0] v);
        return calc_t'({{(CALC_W-SIZE_W){1'b0}}, v});
    endfunction

    function automatic calc_t zext_tile(input logic [TILE_W-1:0] v);
        return calc_t'({{(CALC_W-TILE_W){1'b0}}, v});
    endfunction

    // On an empty range, the low bound is returned only below it; all else gets the high bound
    function automatic calc_t clamp_calc(input calc_t v, input calc_t lo, input calc_t hi);
        calc_t r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/swth_snap.sv
// Shared tile-snap unit: serial floor-remainder by the tile, snap down, clamp.
`include "snapped_window_tracker_hysteresis_core_macros.svh"

module swth_snap (
    input  logic                aclk,
    input  logic                aresetn,
    input  swth_pkg::snap_req_t req,
    output swth_pkg::snap_rsp_t rsp
);
    import swth_pkg::*;

    snap_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    calc_t              a_reg, lo_reg, hi_reg, corner_reg;
    calc_t              req_a, rem_ext, tile_ext, fix_c;
    logic [CALC_W-1:0]  mag_reg, mag_start;
    logic [TILE_W-1:0]  tile_reg, rem_reg;
    logic [TILE_W:0]    rem_sh, rem_sub;
    logic               rem_ge, neg_reg, done_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SN_IDLE: if (req.start) state_next = SN_DIV;
            SN_DIV:  if (cnt_reg == CNT_W'(1)) state_next = SN_FIX;
            SN_FIX:  state_next = SN_IDLE;
            default: state_next = SN_IDLE;
        endcase
    end

    // One restoring step per cycle on the magnitude
    always_comb begin
        req_a     = req.a;
        mag_start = req_a[CALC_W-1] ? $unsigned(-req_a) : $unsigned(req_a);
        rem_sh    = {rem_reg, mag_reg[CALC_W-1]};
        rem_ge    = rem_sh >= {1'b0, tile_reg};
        rem_sub   = rem_sh - {1'b0, tile_reg};
    end

    // Floor snap: a - (a mod t) with a nonnegative modulus, then clamp
    always_comb begin
        rem_ext  = zext_tile(rem_reg);
        tile_ext = zext_tile(tile_reg);
        if (!neg_reg) begin
            fix_c = a_reg - rem_ext;
        end else if (rem_reg == '0) begin
            fix_c = a_reg;
        end else begin
            fix_c = a_reg + rem_ext - tile_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SN_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SN_FIX);
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            SN_IDLE: begin
                if (req.start) begin
                    a_reg    <= req.a;
                    lo_reg   <= req.lo;
                    hi_reg   <= req.hi;
                    tile_reg <= req.tile;
                    neg_reg  <= req_a[CALC_W-1];
                    mag_reg  <= mag_start;
                    rem_reg  <= '0;
                    cnt_reg  <= CNT_W'(DIV_STEPS);
                end
            end
            SN_DIV: begin
                mag_reg <= {mag_reg[CALC_W-2:0], 1'b0};
                rem_reg <= rem_ge ? rem_sub[TILE_W-1:0] : rem_sh[TILE_W-1:0];
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            SN_FIX: begin
                corner_reg <= clamp_calc(fix_c, lo_reg, hi_reg);
            end
            default: begin
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.corner = corner_reg;

    `SWTH_ASSERT_IMPL(a_start_when_idle, aclk, aresetn, req.start, state_reg == SN_IDLE)
    `SWTH_ASSERT_IMPL(a_done_back_idle, aclk, aresetn, done_reg, state_reg == SN_IDLE)

endmodule

// File: rtl/snapped_window_tracker_hysteresis_core.sv
// Top level of the snapped window tracker with hysteresis.
//
// Use: each transfer on the s_ channel carries a viewer cell position and a
// valid flag; the block answers with exactly one transfer on the m_ channel
// holding the window corner, window size and the moved / full_grid flags.
// Grid corner, grid size and wanted window edge are set through the cfg_ write
// port; the user must do so while the block is idle, as the block never checks.
// Flow: a full-grid update goes from accept through the size and output states
// to the output register. Otherwise the corner snap runs on one shared unit
// that does a serial remainder by the tile size, one bit per cycle over 18
// bits. A placed window with a valid viewer takes two snaps; the first
// placement takes four (two with an invalid viewer), and an invalid viewer on
// a placed window takes none.
// Throughput: one update at a time; s_tready is high only while idle, and a
// new update is taken while the previous result still waits on m_.
// Reset clears the window state to unplaced and loads the register defaults.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register frees up; nothing is dropped.
`include "snapped_window_tracker_hysteresis_core_macros.svh"

module snapped_window_tracker_hysteresis_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swth_pkg::IN_DATA_W-1:0]     s_tdata,   // viewer_x, viewer_y
    input  logic                               s_tuser,   // viewer_valid
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // window_min_x, window_min_y, window_size_x, window_size_y, zero pad
    output logic [swth_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [swth_pkg::OUT_USER_W-1:0]    m_tuser,   // moved, full_grid
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [swth_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swth_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import swth_pkg::*;

    trk_state_t          state_reg, state_next;
    snap_sel_t           sel_reg;
    snap_req_t           snap_req;
    snap_rsp_t           snap_rsp;

    logic [COORD_W-1:0]  gmin_x_reg, gmin_y_reg;
    logic [SIZE_W-1:0]   gsize_x_reg, gsize_y_reg, window_reg;
    logic [COORD_W-1:0]  vx_reg, vy_reg, stored_x_reg, stored_y_reg;
    logic                vvalid_reg, placed_reg, far_reg;
    logic [SIZE_W-1:0]   sx_reg, sy_reg;
    logic [TILE_W-1:0]   tile_reg;
    calc_t               hix_reg, hiy_reg, mx_reg, my_reg, cx_reg, cy_reg;

    logic [COORD_W-1:0]  res_x_reg, res_y_reg;
    logic [SIZE_W-1:0]   res_sx_reg, res_sy_reg;
    logic                res_moved_reg, res_full_reg;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    calc_t               gx, gy, gsx, gsy, tile_ext;
    logic                full_cond, take, moved;
    logic [SIZE_W-1:0]   size_x_calc, size_y_calc;
    logic [TILE_W-1:0]   tile_calc;
    calc_t               op_v, op_lo, op_hi;
    logic [SIZE_W-1:0]   op_size;
    calc_t               dx, dy, adx, ady;
    logic [COORD_W-1:0]  nx, ny;
    logic                out_hold;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gmin_x_reg  <= '0;
            gmin_y_reg  <= '0;
            gsize_x_reg <= GRID_SIZE_RST;
            gsize_y_reg <= GRID_SIZE_RST;
            window_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRID_MIN_X:  gmin_x_reg  <= cfg_wdata;
                CFG_GRID_MIN_Y:  gmin_y_reg  <= cfg_wdata;
                CFG_GRID_SIZE_X: gsize_x_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_GRID_SIZE_Y: gsize_y_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_WINDOW:      window_reg  <= cfg_wdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Grid terms, window size and tile
    always_comb begin
        gx          = sext_coord(gmin_x_reg);
        gy          = sext_coord(gmin_y_reg);
        gsx         = zext_size(gsize_x_reg);
        gsy         = zext_size(gsize_y_reg);
        tile_ext    = zext_tile(tile_reg);
        full_cond   = (window_reg == '0) ||
                      ((window_reg >= gsize_x_reg) && (window_reg >= gsize_y_reg));
        size_x_calc = (window_reg < gsize_x_reg) ? window_reg : gsize_x_reg;
        size_y_calc = (window_reg < gsize_y_reg) ? window_reg : gsize_y_reg;
        tile_calc   = (window_reg[SIZE_W-1:3] == '0) ? TILE_W'(1) : window_reg[SIZE_W-1:3];
    end

    // Operand select for the shared snap unit
    always_comb begin
        unique case (sel_reg)
            SEL_CENTER_X: begin
                op_v = gx + zext_size(gsize_x_reg >> 1); op_size = sx_reg;
                op_lo = gx; op_hi = hix_reg;
            end
            SEL_CENTER_Y: begin
                op_v = gy + zext_size(gsize_y_reg >> 1); op_size = sy_reg;
                op_lo = gy; op_hi = hiy_reg;
            end
            SEL_VIEWER_X: begin
                op_v = sext_coord(vx_reg); op_size = sx_reg;
                op_lo = gx; op_hi = hix_reg;
            end
            SEL_VIEWER_Y: begin
                op_v = sext_coord(vy_reg); op_size = sy_reg;
                op_lo = gy; op_hi = hiy_reg;
            end
            default: begin
                op_v = gx; op_size = sx_reg; op_lo = gx; op_hi = hix_reg;
            end
        endcase
        snap_req.start = (state_reg == ST_LAUNCH);
        snap_req.a     = op_v - zext_size(op_size >> 1) + zext_tile(tile_reg >> 1);
        snap_req.tile  = tile_reg;
        snap_req.lo    = op_lo;
        snap_req.hi    = op_hi;
    end

    swth_snap u_snap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (snap_req),
        .rsp     (snap_rsp)
    );

    // Drift from the window center and move decision
    always_comb begin
        dx    = sext_coord(vx_reg) - (mx_reg + zext_size(sx_reg >> 1));
        dy    = sext_coord(vy_reg) - (my_reg + zext_size(sy_reg >> 1));
        adx   = dx[CALC_W-1] ? -dx : dx;
        ady   = dy[CALC_W-1] ? -dy : dy;
        take  = vvalid_reg && (!placed_reg ||
                (far_reg && ((cx_reg != mx_reg) || (cy_reg != my_reg))));
        nx    = take ? cx_reg[COORD_W-1:0] : mx_reg[COORD_W-1:0];
        ny    = take ? cy_reg[COORD_W-1:0] : my_reg[COORD_W-1:0];
        moved = !placed_reg || (nx != stored_x_reg) || (ny != stored_y_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SIZE;
            ST_SIZE:   state_next = full_cond ? ST_OUT : ST_BOUND;
            ST_BOUND:  state_next = ST_BASE;
            ST_BASE:   state_next = placed_reg ? ST_CENTER : ST_LAUNCH;
            ST_LAUNCH: state_next = ST_WAIT;
            ST_WAIT: begin
                if (snap_rsp.done) begin
                    unique case (sel_reg)
                        SEL_CENTER_X: state_next = ST_LAUNCH;
                        SEL_CENTER_Y: state_next = ST_CENTER;
                        SEL_VIEWER_X: state_next = ST_LAUNCH;
                        SEL_VIEWER_Y: state_next = ST_DECIDE;
                        default:      state_next = ST_DECIDE;
                    endcase
                end
            end
            ST_CENTER: state_next = ST_FAR;
            ST_FAR:    state_next = vvalid_reg ? ST_LAUNCH : ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT:    if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
        m_tuser  = m_tuser_reg;
        out_hold = (state_reg == ST_OUT) && m_tvalid_reg && !m_tready;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            placed_reg   <= 1'b0;
            stored_x_reg <= '0;
            stored_y_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SIZE && full_cond) begin
                placed_reg <= 1'b0;
            end
            if (state_reg == ST_DECIDE) begin
                placed_reg   <= 1'b1;
                stored_x_reg <= nx;
                stored_y_reg <= ny;
            end
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    vx_reg     <= s_tdata[COORD_W-1:0];
                    vy_reg     <= s_tdata[2*COORD_W-1:COORD_W];
                    vvalid_reg <= s_tuser;
                end
            end
            ST_SIZE: begin
                sx_reg   <= size_x_calc;
                sy_reg   <= size_y_calc;
                tile_reg <= tile_calc;
                if (full_cond) begin
                    res_x_reg     <= gmin_x_reg;
                    res_y_reg     <= gmin_y_reg;
                    res_sx_reg    <= gsize_x_reg;
                    res_sy_reg    <= gsize_y_reg;
                    res_moved_reg <= 1'b0;
                    res_full_reg  <= 1'b1;
                end
            end
            ST_BOUND: begin
                hix_reg <= gx + gsx - zext_size(sx_reg);
                hiy_reg <= gy + gsy - zext_size(sy_reg);
            end
            ST_BASE: begin
                sel_reg <= SEL_CENTER_X;
                mx_reg  <= clamp_calc(sext_coord(stored_x_reg), gx, hix_reg);
                my_reg  <= clamp_calc(sext_coord(stored_y_reg), gy, hiy_reg);
            end
            ST_WAIT: begin
                if (snap_rsp.done) begin
                    unique case (sel_reg)
                        SEL_CENTER_X: begin
                            mx_reg  <= snap_rsp.corner;
                            sel_reg <= SEL_CENTER_Y;
                        end
                        SEL_CENTER_Y: my_reg <= snap_rsp.corner;
                        SEL_VIEWER_X: begin
                            cx_reg  <= snap_rsp.corner;
                            sel_reg <= SEL_VIEWER_Y;
                        end
                        SEL_VIEWER_Y: cy_reg <= snap_rsp.corner;
                        default: begin
                        end
                    endcase
                end
            end
            ST_CENTER: begin
                // corner wraps to the coordinate width
                mx_reg <= sext_coord(mx_reg[COORD_W-1:0]);
                my_reg <= sext_coord(my_reg[COORD_W-1:0]);
            end
            ST_FAR: begin
                far_reg <= (adx > tile_ext) || (ady > tile_ext);
                sel_reg <= SEL_VIEWER_X;
            end
            ST_DECIDE: begin
                res_x_reg     <= nx;
                res_y_reg     <= ny;
                res_sx_reg    <= sx_reg;
                res_sy_reg    <= sy_reg;
                res_moved_reg <= moved;
                res_full_reg  <= 1'b0;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= {{OUT_PAD_W{1'b0}}, res_sy_reg, res_sx_reg,
                                    res_y_reg, res_x_reg};
                    m_tuser_reg <= {res_full_reg, res_moved_reg};
                end
            end
            default: begin
            end
        endcase
    end

    `SWTH_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SWTH_ASSERT_NEXT(a_result_waits, aclk, aresetn, out_hold, state_reg == ST_OUT)
    `SWTH_ASSERT_IMPL(a_flags_exclusive, aclk, aresetn, m_tvalid_reg, !(&m_tuser_reg))

endmodule
